// File: hw/rtl/ultrasonic_ranger_led_indicator_core_assert.svh
// Assertion macros shared by the ranger RTL; clocked on clk_i, off while rst_ni is low.
`ifndef ULTRASONIC_RANGER_LED_INDICATOR_CORE_ASSERT_SVH
`define ULTRASONIC_RANGER_LED_INDICATOR_CORE_ASSERT_SVH

`define URLI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ranger assertion failed");

`define URLI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ranger implication failed");

`endif

// File: hw/rtl/urli_pkg.sv
package urli_pkg;

  localparam int unsigned TpuW     = 8;
  localparam int unsigned BlinkW   = 26;
  localparam int unsigned PeriodW  = 24;
  localparam int unsigned ScaleW   = 24;
  localparam int unsigned FracW    = 24;
  localparam int unsigned DistW    = 16;
  localparam int unsigned LedW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;
  localparam int unsigned NumBands = 6;
  localparam int unsigned BandIdxW = 3;
  localparam int unsigned BandPMin = 4;

  localparam int unsigned EchoCountWidthDef = 24;
  localparam int unsigned WaitCountWidthDef = 26;

  localparam logic [TpuW-1:0]    TpuRst    = 8'd16;
  localparam logic [BlinkW-1:0]  BlinkRst  = 26'd4000000;
  localparam logic [PeriodW-1:0] PeriodRst = 24'd80000;
  localparam logic [ScaleW-1:0]  ScaleRst  = 24'd17983;

  localparam logic [DistW-1:0] NearCm  = 16'd10;
  localparam logic [DistW-1:0] Band8Cm = 16'd20;
  localparam logic [DistW-1:0] Band7Cm = 16'd30;
  localparam logic [DistW-1:0] Band6Cm = 16'd40;
  localparam logic [DistW-1:0] Band5Cm = 16'd50;
  localparam logic [DistW-1:0] Band4Cm = 16'd60;
  localparam logic [DistW-1:0] FarCm   = 16'd70;

  localparam logic [BandIdxW-1:0] BandP9 = 3'd5;
  localparam logic [BandIdxW-1:0] BandP8 = 3'd4;
  localparam logic [BandIdxW-1:0] BandP7 = 3'd3;
  localparam logic [BandIdxW-1:0] BandP6 = 3'd2;
  localparam logic [BandIdxW-1:0] BandP5 = 3'd1;
  localparam logic [BandIdxW-1:0] BandP4 = 3'd0;

  localparam logic [LedW-1:0] LedOff = 3'b000;
  localparam logic [LedW-1:0] LedAll = 3'b111;

  localparam logic [31:0] Div10Recip = 32'hCCCCCCCD;
  localparam int unsigned Div10Shift = 35;

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_ECHO = 3'd2,
    PH_BLINK     = 3'd3,
    PH_PWM       = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_US   = 2'd0,
    CFG_BLINK_TICKS    = 2'd1,
    CFG_PWM_PERIOD     = 2'd2,
    CFG_DISTANCE_SCALE = 2'd3
  } cfg_idx_e;

  typedef logic [NumBands-1:0][PeriodW-1:0] band_len_t;

  typedef struct packed {
    logic [TpuW-1:0]   tpu;
    logic [BlinkW-1:0] blink;
    band_len_t         hi_len;
    band_len_t         lo_len;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [DistW-1:0] distance;
  } echo_stat_t;

  typedef struct packed {
    logic            trigger;
    logic [LedW-1:0] led;
  } ctrl_out_t;

  // floor(period * p / 10) through a reciprocal multiply, exact below 2^32
  function automatic logic [PeriodW-1:0] hi_duty(input logic [PeriodW-1:0] period,
                                                 input logic [3:0] p);
    logic [PeriodW+3:0]  x;
    logic [PeriodW+35:0] m;
    x = {4'b0, period} * {{PeriodW{1'b0}}, p};
    m = {32'b0, x} * {{(PeriodW+4){1'b0}}, Div10Recip};
    return m[PeriodW+Div10Shift-1:Div10Shift];
  endfunction

  function automatic logic [PeriodW-1:0] dec_floor(input logic [PeriodW-1:0] d);
    return (d == '0) ? '0 : d - PeriodW'(1);
  endfunction

  function automatic band_len_t hi_len_table(input logic [PeriodW-1:0] period);
    band_len_t t;
    for (int b = 0; b < NumBands; b++) begin
      t[b] = dec_floor(hi_duty(period, 4'(b + BandPMin)));
    end
    return t;
  endfunction

  function automatic band_len_t lo_len_table(input logic [PeriodW-1:0] period);
    band_len_t t;
    for (int b = 0; b < NumBands; b++) begin
      t[b] = dec_floor(period - hi_duty(period, 4'(b + BandPMin)));
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/urli_cfg.sv
module urli_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [urli_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [urli_pkg::CfgDataW-1:0] cfg_wdata_i,
  output urli_pkg::cfg_t                cfg_o,
  output logic [urli_pkg::ScaleW-1:0]   scale_d_o
);
  import urli_pkg::*;

  localparam band_len_t HiLenRst = hi_len_table(PeriodRst);
  localparam band_len_t LoLenRst = lo_len_table(PeriodRst);

  logic [TpuW-1:0]    tpu_q, tpu_d;
  logic [BlinkW-1:0]  blink_q, blink_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [ScaleW-1:0]  scale_q, scale_d;
  band_len_t          hi_len_q, hi_len_d;
  band_len_t          lo_len_q, lo_len_d;

  always_comb begin
    tpu_d    = tpu_q;
    blink_d  = blink_q;
    period_d = period_q;
    scale_d  = scale_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TICKS_PER_US:   tpu_d    = cfg_wdata_i[TpuW-1:0];
        CFG_BLINK_TICKS:    blink_d  = cfg_wdata_i[BlinkW-1:0];
        CFG_PWM_PERIOD:     period_d = cfg_wdata_i[PeriodW-1:0];
        CFG_DISTANCE_SCALE: scale_d  = cfg_wdata_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // precompute the per-band PWM wait lengths
  always_comb begin
    hi_len_d = hi_len_table(period_d);
    lo_len_d = lo_len_table(period_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q    <= TpuRst;
      blink_q  <= BlinkRst;
      period_q <= PeriodRst;
      scale_q  <= ScaleRst;
      hi_len_q <= HiLenRst;
      lo_len_q <= LoLenRst;
    end else begin
      tpu_q    <= tpu_d;
      blink_q  <= blink_d;
      period_q <= period_d;
      scale_q  <= scale_d;
      hi_len_q <= hi_len_d;
      lo_len_q <= lo_len_d;
    end
  end

  assign cfg_o.tpu    = tpu_q;
  assign cfg_o.blink  = blink_q;
  assign cfg_o.hi_len = hi_len_q;
  assign cfg_o.lo_len = lo_len_q;
  assign scale_d_o    = scale_d;

endmodule

// File: hw/rtl/urli_echo.sv
`include "ultrasonic_ranger_led_indicator_core_assert.svh"

module urli_echo #(
  parameter int unsigned ECHO_COUNT_WIDTH = urli_pkg::EchoCountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        echo_i,
  input  logic                        pass_start_i,
  input  logic [urli_pkg::ScaleW-1:0] scale_d_i,
  output urli_pkg::echo_stat_t        stat_o,
  output logic [urli_pkg::DistW-1:0]  dist_d_o,
  output logic                        latch_o
);
  import urli_pkg::*;

  localparam int unsigned ProdW = ECHO_COUNT_WIDTH + FracW;
  localparam logic [ECHO_COUNT_WIDTH-1:0] EchoMax = '1;
  localparam logic [ECHO_COUNT_WIDTH-1:0] EchoOne = ECHO_COUNT_WIDTH'(1);

  logic [ECHO_COUNT_WIDTH-1:0] cnt_q, cnt_d, base;
  logic                        prev_q, prev_d;
  logic                        done_q, done_d;
  logic [DistW-1:0]            dist_q, dist_d, dist_sat;
  logic [ProdW-1:0]            prod_q, prod_d;
  logic [ECHO_COUNT_WIDTH-1:0] prod_hi;
  logic                        latch;

  // prod_q always equals cnt_q * scale
  assign prod_hi  = prod_q[ProdW-1:FracW];
  assign dist_sat = (33'(prod_hi) > 33'({DistW{1'b1}})) ? '1 : prod_hi[DistW-1:0];

  always_comb begin
    cnt_d  = cnt_q;
    prev_d = prev_q;
    done_d = done_q;
    dist_d = dist_q;
    latch  = 1'b0;
    base   = '0;
    if (adv_i) begin
      if (pass_start_i) begin
        done_d = 1'b0;
        dist_d = '0;
      end
      if (echo_i) begin
        base  = prev_q ? cnt_q : '0;
        cnt_d = (base == EchoMax) ? EchoMax : base + EchoOne;
      end else if (prev_q) begin
        dist_d = dist_sat;
        done_d = 1'b1;
        latch  = 1'b1;
      end
      prev_d = echo_i;
    end
    prod_d = ProdW'(cnt_d) * ProdW'(scale_d_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= 1'b0;
      done_q <= 1'b0;
      dist_q <= '0;
      prod_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      prev_q <= prev_d;
      done_q <= done_d;
      dist_q <= dist_d;
      prod_q <= prod_d;
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.distance = dist_q;
  assign dist_d_o        = dist_d;
  assign latch_o         = latch;

  `URLI_ASSERT_NEXT(fall_marks_done, adv_i && !echo_i && prev_q, done_q)
  `URLI_ASSERT_NEXT(rise_restarts_count, adv_i && echo_i && !prev_q, cnt_q == EchoOne)

endmodule

// File: hw/rtl/urli_ctrl.sv
`include "ultrasonic_ranger_led_indicator_core_assert.svh"

module urli_ctrl #(
  parameter int unsigned WAIT_COUNT_WIDTH = urli_pkg::WaitCountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  urli_pkg::cfg_t       cfg_i,
  input  urli_pkg::echo_stat_t stat_i,
  output logic                 pass_start_o,
  output urli_pkg::ctrl_out_t  out_o
);
  import urli_pkg::*;

  localparam logic [32:0] WaitMax = 33'((33'd1 << WAIT_COUNT_WIDTH) - 33'd1);
  localparam logic [WAIT_COUNT_WIDTH-1:0] CntOne = WAIT_COUNT_WIDTH'(1);

  phase_e                      phase_q, phase_d;
  logic [WAIT_COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [LedW-1:0]             led_q, led_d;
  logic [BandIdxW-1:0]         band;
  logic [PeriodW-1:0]          pwm_len;
  logic [32:0]                 wait_n, wait_m1, wait_lim;
  logic                        wait_hit;
  logic                        pass_start;

  always_comb begin
    if (stat_i.distance < Band8Cm) begin
      band = BandP9;
    end else if (stat_i.distance < Band7Cm) begin
      band = BandP8;
    end else if (stat_i.distance < Band6Cm) begin
      band = BandP7;
    end else if (stat_i.distance < Band5Cm) begin
      band = BandP6;
    end else if (stat_i.distance < Band4Cm) begin
      band = BandP5;
    end else begin
      band = BandP4;
    end
  end

  assign pwm_len = (led_q != LedOff) ? cfg_i.hi_len[band] : cfg_i.lo_len[band];

  always_comb begin
    case (phase_q)
      PH_TRIG_HIGH: wait_n = 33'({cfg_i.tpu, 3'b000}) + 33'({cfg_i.tpu, 1'b0});
      PH_BLINK:     wait_n = 33'(cfg_i.blink);
      PH_PWM:       wait_n = 33'(pwm_len);
      default:      wait_n = 33'({cfg_i.tpu, 1'b0});
    endcase
    wait_m1  = (wait_n == '0) ? '0 : wait_n - 33'd1;
    wait_lim = (wait_m1 > WaitMax) ? WaitMax : wait_m1;
    wait_hit = 33'(cnt_q) >= wait_lim;
  end

  assign cnt_inc = cnt_q + CntOne;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    led_d      = led_q;
    pass_start = 1'b0;
    if (adv_i) begin
      case (phase_q)
        PH_TRIG_LOW: begin
          if (wait_hit) begin
            phase_d = PH_TRIG_HIGH;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_TRIG_HIGH: begin
          if (wait_hit) begin
            phase_d = PH_WAIT_ECHO;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_WAIT_ECHO: begin
          if (stat_i.done) begin
            cnt_d = '0;
            if (stat_i.distance < NearCm) begin
              phase_d = PH_BLINK;
            end else if (stat_i.distance < FarCm) begin
              led_d   = (led_q != LedOff) ? LedOff : LedAll;
              phase_d = PH_PWM;
            end else begin
              led_d      = LedOff;
              phase_d    = PH_TRIG_LOW;
              pass_start = 1'b1;
            end
          end
        end
        PH_BLINK: begin
          if (wait_hit) begin
            led_d      = {2'b00, ~led_q[0]};
            phase_d    = PH_TRIG_LOW;
            cnt_d      = '0;
            pass_start = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_PWM: begin
          if (wait_hit) begin
            phase_d    = PH_TRIG_LOW;
            cnt_d      = '0;
            pass_start = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: begin
          if (wait_lim == '0) begin
            phase_d = PH_TRIG_HIGH;
            cnt_d   = '0;
          end else begin
            phase_d = PH_TRIG_LOW;
            cnt_d   = CntOne;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_o.trigger = (phase_d == PH_TRIG_HIGH);
    out_o.led     = led_d;
    pass_start_o  = pass_start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TRIG_LOW;
      cnt_q   <= '0;
      led_q   <= LedOff;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      led_q   <= led_d;
    end
  end

  `URLI_ASSERT_NEXT(far_restarts_pass,
      adv_i && phase_q == PH_WAIT_ECHO && stat_i.done && stat_i.distance >= FarCm,
      phase_q == PH_TRIG_LOW)
  `URLI_ASSERT_NEXT(wait_holds_until_done,
      adv_i && phase_q == PH_WAIT_ECHO && !stat_i.done, phase_q == PH_WAIT_ECHO)

endmodule

// File: hw/rtl/ultrasonic_ranger_led_indicator_core.sv
// A request accepted into the input register loads the result register when
// it advances, which a stalled output holds off. Throughput: one request per
// cycle while the output is not stalled; the single input register feeding the
// result register through the phase, echo and LED update sets that rate.
// Reset (rst_ni low, asynchronous): the pass restarts in the trigger-low phase,
// counters, distance and LED state clear; echo/output registers are not reset.
`include "ultrasonic_ranger_led_indicator_core_assert.svh"

module ultrasonic_ranger_led_indicator_core #(
  parameter int unsigned ECHO_COUNT_WIDTH = urli_pkg::EchoCountWidthDef,
  parameter int unsigned WAIT_COUNT_WIDTH = urli_pkg::WaitCountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          echo_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trigger_out_o,
  output logic                          red_led_o,
  output logic                          blue_led_o,
  output logic                          green_led_o,
  output logic [urli_pkg::DistW-1:0]    range_cm_o,
  output logic                          range_valid_o,
  input  logic                          cfg_we_i,
  input  logic [urli_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [urli_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import urli_pkg::*;

  logic             in_vld_q, in_vld_d;
  logic             echo_q;
  logic             accept, adv;
  logic             out_vld_q, out_vld_d;
  logic             trig_q;
  logic [LedW-1:0]  led_q;
  logic [DistW-1:0] range_q;
  logic             rvalid_q;

  cfg_t             cfg;
  logic [ScaleW-1:0] scale_d;
  echo_stat_t       stat;
  logic [DistW-1:0] dist_d;
  logic             latch;
  logic             pass_start;
  ctrl_out_t        ctrl_out;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      echo_q <= echo_level_i;
    end
    if (adv) begin
      trig_q   <= ctrl_out.trigger;
      led_q    <= ctrl_out.led;
      range_q  <= dist_d;
      rvalid_q <= latch;
    end
  end

  urli_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .scale_d_o   (scale_d)
  );

  urli_ctrl #(
    .WAIT_COUNT_WIDTH (WAIT_COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .cfg_i        (cfg),
    .stat_i       (stat),
    .pass_start_o (pass_start),
    .out_o        (ctrl_out)
  );

  urli_echo #(
    .ECHO_COUNT_WIDTH (ECHO_COUNT_WIDTH)
  ) u_echo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .echo_i       (echo_q),
    .pass_start_i (pass_start),
    .scale_d_i    (scale_d),
    .stat_o       (stat),
    .dist_d_o     (dist_d),
    .latch_o      (latch)
  );

  assign out_valid_o   = out_vld_q;
  assign trigger_out_o = trig_q;
  assign red_led_o     = led_q[0];
  assign blue_led_o    = led_q[1];
  assign green_led_o   = led_q[2];
  assign range_cm_o    = range_q;
  assign range_valid_o = rvalid_q;

  `URLI_ASSERT_NEXT(held_request_kept, in_vld_q && !adv, in_vld_q)
  `URLI_ASSERT(stall_only_when_full, in_stall_o |-> (out_vld_q && out_stall_i))

endmodule
